/* rtl/tss_pkg.sv */
// ---------------------------------------------------------------------------
// tss_pkg: shared types and constants for the time step snap search
// Register indexes, snap modes, item kinds and fixed field widths.
// ---------------------------------------------------------------------------
package tss_pkg;

  // fixed field widths
  localparam int unsigned IDX_W       = 6;  // entry_index / chosen_index
  localparam int unsigned MODE_W      = 2;  // snap_mode register
  localparam int unsigned COUNT_W     = 7;  // entry_count register
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SNAP_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b1;

  // item kinds on the input tuser
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    SNAP_NEAREST = 2'd0,
    SNAP_BELOW   = 2'd1,
    SNAP_ABOVE   = 2'd2
  } snap_mode_e;

endpackage

/* rtl/time_step_snap_search.sv */
// ---------------------------------------------------------------------------
// time_step_snap_search
// Sorted time table with nearest / floor / ceiling snap of a query time.
// ---------------------------------------------------------------------------
// Load item: written into the table RAM in the transfer cycle, no result.
// Query item: one table read per cycle over entry_count entries (single RAM
//   read port, registered read data); the result is loaded in ST_FINISH after
//   the scan, or as a pass-through when entry_count is 0, later while an older
//   result is still held. Input is busy until then; the next item is taken
//   while the result waits in the output register. Reset clears control state.
module time_step_snap_search #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned TIME_BITS   = 32
) (
  input  logic clk_i,
  input  logic rst_ni,

  // input stream
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // tdata: entry_index[5:0], time_value[TIME_BITS-1:0], zero pad
  input  logic [((tss_pkg::IDX_W + TIME_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  // tuser: kind
  input  logic [0:0] s_axis_tuser_i,

  // result stream
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // tdata: snapped_time[TIME_BITS-1:0], chosen_index[5:0], zero pad
  output logic [((tss_pkg::IDX_W + TIME_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata_o,
  // tuser: from_table
  output logic [0:0] m_axis_tuser_o,

  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tss_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tss_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import tss_pkg::*;

  localparam int unsigned IdxW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CmpW  = (CntW > COUNT_W) ? CntW : COUNT_W;
  localparam int unsigned DiffW = TIME_BITS + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e state_q;

  // configuration
  logic [MODE_W-1:0]  snap_mode_q;
  logic [COUNT_W-1:0] entry_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_mode_q   <= '0;
      entry_count_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SNAP_MODE:   snap_mode_q   <= cfg_data_i[MODE_W-1:0];
        CFG_ENTRY_COUNT: entry_count_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // input unpack
  logic                        in_kind;
  logic [IDX_W-1:0]            in_idx;
  logic signed [TIME_BITS-1:0] in_time;
  logic                        in_xfer;
  logic [CmpW-1:0]             in_idx_wide;
  logic [CmpW-1:0]             count_wide;
  logic [CntW-1:0]             count_eff;

  assign in_kind     = s_axis_tuser_i[0];
  assign in_idx      = s_axis_tdata_i[IDX_W-1:0];
  assign in_time     = s_axis_tdata_i[IDX_W +: TIME_BITS];
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer     = s_axis_tvalid_i && s_axis_tready_o;
  assign in_idx_wide = CmpW'(in_idx);
  assign count_wide  = (CmpW'(entry_count_q) > CmpW'(TABLE_DEPTH)) ?
                       CmpW'(TABLE_DEPTH) : CmpW'(entry_count_q);
  assign count_eff   = count_wide[CntW-1:0];

  // table RAM: one write port (loads), one registered read port (scan).
  // Loads are only taken in idle, so a read never overlaps a write.
  logic signed [TIME_BITS-1:0] time_table [TABLE_DEPTH];
  logic                        mem_we;
  logic [IdxW-1:0]             mem_waddr;
  logic                        rd_en;
  logic [IdxW-1:0]             rd_addr;
  logic signed [TIME_BITS-1:0] rd_data_q;

  assign mem_we    = in_xfer && (in_kind == KIND_LOAD) &&
                     (in_idx_wide < CmpW'(TABLE_DEPTH));
  assign mem_waddr = in_idx_wide[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      time_table[mem_waddr] <= in_time;
    end
    if (rd_en) begin
      rd_data_q <= time_table[rd_addr];
    end
  end

  // scan control
  logic [CntW-1:0]             cnt_q;
  logic [CntW-1:0]             rd_cnt_q;
  logic                        ev_valid_q;
  logic [CntW-1:0]             ev_idx_q;
  logic                        ev_last;
  logic signed [TIME_BITS-1:0] query_q;

  assign rd_en   = (state_q == ST_SCAN) && (rd_cnt_q != cnt_q);
  assign rd_addr = rd_cnt_q[IdxW-1:0];
  assign ev_last = ev_valid_q && (CntW'(ev_idx_q + 1'b1) == cnt_q);

  // evaluation of one entry
  logic                        found_q, found_d;
  logic                        stop_q, stop_d;
  logic [IdxW-1:0]             pick_q, pick_d;
  logic signed [TIME_BITS-1:0] pick_val_q, pick_val_d;
  logic signed [TIME_BITS-1:0] first_val_q;
  logic [DiffW-1:0]            best_q, best_d;
  logic signed [DiffW-1:0]     q_ext, e_ext, diff_qe, diff_eq;
  logic [DiffW-1:0]            abs_d;

  assign q_ext   = DiffW'(query_q);
  assign e_ext   = DiffW'(rd_data_q);
  assign diff_qe = q_ext - e_ext;
  assign diff_eq = e_ext - q_ext;
  assign abs_d   = diff_qe[DiffW-1] ? diff_eq : diff_qe;

  always_comb begin
    found_d    = found_q;
    stop_d     = stop_q;
    pick_d     = pick_q;
    pick_val_d = pick_val_q;
    best_d     = best_q;
    if (ev_valid_q && !stop_q) begin
      unique case (snap_mode_e'(snap_mode_q))
        SNAP_NEAREST: begin
          // strict less-than keeps the earliest entry on a tie
          if (!found_q || (abs_d < best_q)) begin
            found_d    = 1'b1;
            best_d     = abs_d;
            pick_d     = ev_idx_q[IdxW-1:0];
            pick_val_d = rd_data_q;
          end
        end
        SNAP_BELOW: begin
          if (rd_data_q > query_q) begin
            stop_d = 1'b1;
          end else begin
            found_d    = 1'b1;
            pick_d     = ev_idx_q[IdxW-1:0];
            pick_val_d = rd_data_q;
            if (rd_data_q == query_q) begin
              stop_d = 1'b1;
            end
          end
        end
        SNAP_ABOVE: begin
          if (rd_data_q >= query_q) begin
            found_d    = 1'b1;
            stop_d     = 1'b1;
            pick_d     = ev_idx_q[IdxW-1:0];
            pick_val_d = rd_data_q;
          end
        end
        default: ;  // unused mode selects nothing, entry 0 is returned
      endcase
    end
  end

  // result register
  logic                        out_valid_q;
  logic signed [TIME_BITS-1:0] out_time_q;
  logic [IDX_W-1:0]            out_idx_q;
  logic                        out_from_table_q;
  logic                        out_free;
  logic                        res_load;
  logic [CmpW-1:0]             pick_wide;

  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign res_load  = (state_q == ST_FINISH) && out_free;
  assign pick_wide = CmpW'(pick_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rd_cnt_q    <= '0;
      ev_valid_q  <= 1'b0;
      ev_idx_q    <= '0;
      found_q     <= 1'b0;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer && (in_kind == KIND_QUERY)) begin
            query_q    <= in_time;
            cnt_q      <= count_eff;
            rd_cnt_q   <= '0;
            ev_valid_q <= 1'b0;
            found_q    <= 1'b0;
            stop_q     <= 1'b0;
            state_q    <= (count_eff == '0) ? ST_FINISH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            rd_cnt_q <= CntW'(rd_cnt_q + 1'b1);
          end
          ev_valid_q <= rd_en;
          ev_idx_q   <= rd_cnt_q;
          found_q    <= found_d;
          stop_q     <= stop_d;
          pick_q     <= pick_d;
          pick_val_q <= pick_val_d;
          best_q     <= best_d;
          if (ev_valid_q && (ev_idx_q == '0)) begin
            first_val_q <= rd_data_q;
          end
          if (ev_last) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            if (cnt_q == '0) begin
              out_time_q       <= query_q;
              out_idx_q        <= '0;
              out_from_table_q <= 1'b0;
            end else begin
              out_time_q       <= found_q ? pick_val_q : first_val_q;
              out_idx_q        <= found_q ? pick_wide[IDX_W-1:0] : '0;
              out_from_table_q <= 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tuser_o[0] = out_from_table_q;

  always_comb begin
    m_axis_tdata_o                       = '0;
    m_axis_tdata_o[TIME_BITS-1:0]        = out_time_q;
    m_axis_tdata_o[TIME_BITS +: IDX_W]   = out_idx_q;
  end

  // assertions
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_kind == KIND_LOAD) |=> !$rose(m_axis_tvalid_o))
    else $error("load transfer produced a result");

  a_query_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_kind == KIND_QUERY) |=> (state_q != ST_IDLE))
    else $error("query transfer did not start a search");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (rd_cnt_q < cnt_q))
    else $error("table read beyond entry count");

  a_eval_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) && ev_valid_q |-> (ev_idx_q < cnt_q))
    else $error("evaluated entry beyond entry count");

  a_passthrough_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> (out_idx_q == '0))
    else $error("pass-through result with nonzero index");

endmodule
